[rtl/etpe_pkg.sv]
// Package for the encoder / range position estimator.
// Holds field widths, opcodes, register indexes and the divider request/response types.
// No dependencies.
`timescale 1ns / 1ps

package etpe_pkg;

  // Field widths
  localparam int OP_W    = 2;
  localparam int ENC_W   = 32;
  localparam int RNG_W   = 16;
  localparam int INTV_W  = 20;
  localparam int POS_W   = 32;
  localparam int VEL_W   = 32;
  localparam int MPC_W   = 24;
  localparam int THR_W   = 24;
  localparam int GAIN_W  = 17;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Divider dividend magnitude width (|mm| <= 2^33 times 10^6 fits)
  localparam int DIV_MAG_W = 54;

  // Opcodes
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_W-1:0] OP_FORCE  = 2'd1;
  localparam logic [OP_W-1:0] OP_RESYNC = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_MIN_RNG  = 3'd1;
  localparam logic [2:0] REG_MPC      = 3'd2;
  localparam logic [2:0] REG_SLIP_THR = 3'd3;
  localparam logic [2:0] REG_NGAIN    = 3'd4;
  localparam logic [2:0] REG_RGAIN    = 3'd5;

  // Reset values of the registers
  localparam logic [MPC_W-1:0]  MPC_RST   = 24'd65536;
  localparam logic [THR_W-1:0]  THR_RST   = 24'd2560;
  localparam logic [GAIN_W-1:0] NGAIN_RST = 17'd6554;
  localparam logic [GAIN_W-1:0] RGAIN_RST = 17'd32768;
  localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'd65536;

  // Divider request
  typedef struct packed {
    logic                 start;
    logic                 neg;
    logic [DIV_MAG_W-1:0] mag;
    logic [INTV_W-1:0]    divisor;
  } div_req_t;

  // Divider response: quotient already signed and saturated
  typedef struct packed {
    logic                    done;
    logic signed [VEL_W-1:0] quot;
  } div_rsp_t;

endpackage

[rtl/etpe_div.sv]
// Serial restoring divider: signed dividend magnitude over an unsigned interval.
// One quotient bit per cycle, 32 steps; truncates toward zero, saturates to 32 bits.
// Depends on etpe_pkg.
`timescale 1ns / 1ps

module etpe_div (
  input  logic                clk,
  input  logic                rst_n,
  input  etpe_pkg::div_req_t  req,
  output etpe_pkg::div_rsp_t  rsp
);

  localparam int CNT_W = $clog2(etpe_pkg::VEL_W);
  localparam int HI_W  = etpe_pkg::DIV_MAG_W - etpe_pkg::VEL_W;

  logic                            busy_r;
  logic                            done_r;
  logic                            ovf_r;
  logic                            neg_r;
  logic [CNT_W-1:0]                cnt_r;
  logic [etpe_pkg::INTV_W-1:0]     d_r;
  logic [etpe_pkg::INTV_W-1:0]     rem_r;
  logic [etpe_pkg::VEL_W-1:0]      lo_r;

  logic [HI_W-1:0]                 hi;
  logic                            ovf;
  logic [etpe_pkg::INTV_W:0]       trial;
  logic                            ge;
  logic [etpe_pkg::INTV_W:0]       diff;

  // Quotient overflows 32 bits when the high part already reaches the divisor
  assign hi  = req.mag[etpe_pkg::DIV_MAG_W-1:etpe_pkg::VEL_W];
  assign ovf = hi >= HI_W'(req.divisor);

  // One restoring step
  assign trial = {rem_r, lo_r[etpe_pkg::VEL_W-1]};
  assign ge    = trial >= {1'b0, d_r};
  assign diff  = trial - {1'b0, d_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (ovf_r || cnt_r == CNT_W'(etpe_pkg::VEL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      ovf_r <= ovf;
      neg_r <= req.neg;
      d_r   <= req.divisor;
      rem_r <= hi[etpe_pkg::INTV_W-1:0];
      lo_r  <= req.mag[etpe_pkg::VEL_W-1:0];
    end else if (busy_r && !ovf_r) begin
      rem_r <= ge ? diff[etpe_pkg::INTV_W-1:0] : trial[etpe_pkg::INTV_W-1:0];
      lo_r  <= {lo_r[etpe_pkg::VEL_W-2:0], ge};
    end
  end

  // Apply sign and saturate
  always_comb begin
    rsp.done = done_r;
    if (neg_r) begin
      if (ovf_r || lo_r[etpe_pkg::VEL_W-1]) begin
        rsp.quot = {1'b1, {(etpe_pkg::VEL_W-1){1'b0}}};
      end else begin
        rsp.quot = -$signed(lo_r);
      end
    end else begin
      if (ovf_r || lo_r[etpe_pkg::VEL_W-1]) begin
        rsp.quot = {1'b0, {(etpe_pkg::VEL_W-1){1'b1}}};
      end else begin
        rsp.quot = $signed(lo_r);
      end
    end
  end

endmodule

[rtl/encoder_tof_position_estimator_core.sv]
// Top level of the encoder / time-of-flight position estimator.
// Sequencer around one shared signed multiplier; uses etpe_pkg and etpe_div.
//
//   port group   dir   handshake                       payload
//   in_*         in    in_valid / in_ready             opcode, count, range, interval, force
//   out_*        out   out_valid / out_ready           position, velocity, range, flags
//   APB          in    psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// In fusion mode an update item spends most of its time in the 32-step serial
// divider for velocity, plus up to three passes through the multiplier.
// Force, resync and unused opcodes go from idle straight to the output step. in_ready is high only in idle.
// A finished item sits in the output register; the next item is taken meanwhile,
// and the sequencer holds its last step while that register is still full.
// Reset is synchronous: estimator state clears and registers take their defaults.
`timescale 1ns / 1ps

module encoder_tof_position_estimator_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input items
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [etpe_pkg::OP_W-1:0]             in_opcode,
  input  logic signed [etpe_pkg::ENC_W-1:0]     in_encoder_count,
  input  logic                                  in_range_flag,
  input  logic [etpe_pkg::RNG_W-1:0]            in_range_mm,
  input  logic [etpe_pkg::INTV_W-1:0]           in_interval_us,
  input  logic signed [etpe_pkg::POS_W-1:0]     in_forced_position,
  // Result items
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [etpe_pkg::POS_W-1:0]     out_position,
  output logic signed [etpe_pkg::VEL_W-1:0]     out_velocity,
  output logic [etpe_pkg::RNG_W-1:0]            out_latest_range_mm,
  output logic                                  out_range_accepted,
  output logic                                  out_slip_flag,
  // Configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [etpe_pkg::ADDR_W-1:0]           paddr,
  input  logic [etpe_pkg::DATA_W-1:0]           pwdata,
  output logic [etpe_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);

  localparam int SUM_W  = 52;
  localparam int DMM_W  = etpe_pkg::PROD_W - 8;
  localparam int CORR_W = etpe_pkg::PROD_W - 16;
  localparam int ERR_W  = 34;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RNG  = 4'd1;
  localparam logic [3:0] S_ENC  = 4'd2;
  localparam logic [3:0] S_POS  = 4'd3;
  localparam logic [3:0] S_VMUL = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_DIVW = 4'd6;
  localparam logic [3:0] S_ERR  = 4'd7;
  localparam logic [3:0] S_CMUL = 4'd8;
  localparam logic [3:0] S_CPOS = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  localparam logic signed [DMM_W-1:0] MM_LIM = DMM_W'(64'sd8589934592);
  localparam logic signed [etpe_pkg::MUL_B_W-1:0] VEL_SCALE = 24'sd1000000;

  // Saturate a wide sum to 32 bits
  function automatic logic signed [etpe_pkg::POS_W-1:0] sat32(
    input logic signed [SUM_W-1:0] x
  );
    logic hi_same;
    hi_same = (x[SUM_W-1:etpe_pkg::POS_W-1] == '0) ||
              (x[SUM_W-1:etpe_pkg::POS_W-1] == '1);
    if (hi_same) begin
      sat32 = x[etpe_pkg::POS_W-1:0];
    end else if (x[SUM_W-1]) begin
      sat32 = {1'b1, {(etpe_pkg::POS_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(etpe_pkg::POS_W-1){1'b1}}};
    end
  endfunction

  // Configuration registers
  logic                              mode_r;
  logic [etpe_pkg::RNG_W-1:0]        min_rng_r;
  logic signed [etpe_pkg::MPC_W-1:0] mpc_r;
  logic [etpe_pkg::THR_W-1:0]        thr_r;
  logic [etpe_pkg::GAIN_W-1:0]       ngain_r;
  logic [etpe_pkg::GAIN_W-1:0]       rgain_r;
  logic                              cfg_wr;

  // Sequencer and estimator state
  logic [3:0]                        state_r, state_nxt;
  logic signed [etpe_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic signed [etpe_pkg::VEL_W-1:0] vel_r, vel_nxt;
  logic [etpe_pkg::ENC_W-1:0]        penc_r, penc_nxt;
  logic                              seen_r, seen_nxt;
  logic [etpe_pkg::RNG_W-1:0]        prng_r, prng_nxt;
  logic                              prng_ok_r, prng_ok_nxt;
  logic                              slip_r, slip_nxt;
  logic                              out_valid_r, out_valid_nxt;

  // Item and work registers
  logic [etpe_pkg::ENC_W-1:0]          enc_r;
  logic [etpe_pkg::RNG_W-1:0]          rng_r;
  logic [etpe_pkg::INTV_W-1:0]         intv_r;
  logic                                acc_r, acc_nxt;
  logic signed [etpe_pkg::MUL_A_W-1:0] mm_r, mm_nxt;
  logic signed [ERR_W-1:0]             err_r, err_nxt;
  logic [etpe_pkg::GAIN_W-1:0]         gain_r, gain_nxt;
  logic signed [etpe_pkg::PROD_W-1:0]  prod_r;

  // Output registers
  logic signed [etpe_pkg::POS_W-1:0] out_pos_r;
  logic signed [etpe_pkg::VEL_W-1:0] out_vel_r;
  logic [etpe_pkg::RNG_W-1:0]        out_rng_r;
  logic                              out_acc_r;
  logic                              out_slip_r;

  // Shared multiplier operands
  logic signed [etpe_pkg::MUL_A_W-1:0] mul_a;
  logic signed [etpe_pkg::MUL_B_W-1:0] mul_b;
  logic signed [etpe_pkg::PROD_W-1:0]  prod_nxt;

  logic                                in_acc;
  logic                                out_load;
  logic                                intv_zero;
  logic [etpe_pkg::ENC_W-1:0]          delta;
  logic signed [etpe_pkg::PROD_W-1:0]  rnd;
  logic signed [DMM_W-1:0]             dmm;
  logic signed [CORR_W-1:0]            corr;
  logic signed [etpe_pkg::RNG_W:0]     rdiff;
  logic signed [ERR_W-1:0]             err;
  logic [ERR_W-1:0]                    err_mag;
  logic                                slip_now;
  logic [etpe_pkg::GAIN_W-1:0]         gain_sel;

  etpe_pkg::div_req_t div_req;
  etpe_pkg::div_rsp_t div_rsp;

  etpe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      min_rng_r <= '0;
      mpc_r     <= etpe_pkg::MPC_RST;
      thr_r     <= etpe_pkg::THR_RST;
      ngain_r   <= etpe_pkg::NGAIN_RST;
      rgain_r   <= etpe_pkg::RGAIN_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        etpe_pkg::REG_MODE:     mode_r    <= pwdata[0];
        etpe_pkg::REG_MIN_RNG:  min_rng_r <= pwdata[etpe_pkg::RNG_W-1:0];
        etpe_pkg::REG_MPC:      mpc_r     <= pwdata[etpe_pkg::MPC_W-1:0];
        etpe_pkg::REG_SLIP_THR: thr_r     <= pwdata[etpe_pkg::THR_W-1:0];
        etpe_pkg::REG_NGAIN:    ngain_r   <= pwdata[etpe_pkg::GAIN_W-1:0];
        etpe_pkg::REG_RGAIN:    rgain_r   <= pwdata[etpe_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[4:2])
      etpe_pkg::REG_MODE:     prdata = {31'd0, mode_r};
      etpe_pkg::REG_MIN_RNG:  prdata = {16'd0, min_rng_r};
      etpe_pkg::REG_MPC:      prdata = {8'd0, mpc_r};
      etpe_pkg::REG_SLIP_THR: prdata = {8'd0, thr_r};
      etpe_pkg::REG_NGAIN:    prdata = {15'd0, ngain_r};
      etpe_pkg::REG_RGAIN:    prdata = {15'd0, rgain_r};
      default:                prdata = '0;
    endcase
  end

  // Handshake
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign intv_zero = (intv_r == '0);

  // Datapath pieces shared across steps
  assign delta = seen_r ? (enc_r - penc_r) : '0;
  assign rnd   = prod_r + ((state_r == S_CPOS) ? etpe_pkg::PROD_W'(32768)
                                                : etpe_pkg::PROD_W'(128));
  assign dmm   = rnd[etpe_pkg::PROD_W-1:8];
  assign corr  = rnd[etpe_pkg::PROD_W-1:16];
  assign rdiff = $signed({1'b0, rng_r}) - $signed({1'b0, prng_r});
  assign err   = $signed({10'd0, rng_r, 8'd0}) - ERR_W'(pos_r);
  assign err_mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign slip_now = err_mag > ERR_W'(thr_r);

  always_comb begin
    gain_sel = slip_now ? rgain_r : ngain_r;
    if (gain_sel > etpe_pkg::GAIN_ONE) begin
      gain_sel = etpe_pkg::GAIN_ONE;
    end
  end

  // Shared multiplier, registered
  assign prod_nxt = mul_a * mul_b;

  // Divider request: dividend is the registered velocity product
  always_comb begin
    div_req.start   = (state_r == S_DIV);
    div_req.neg     = prod_r[etpe_pkg::PROD_W-1];
    div_req.mag     = prod_r[etpe_pkg::PROD_W-1] ?
                      etpe_pkg::DIV_MAG_W'(-prod_r) : etpe_pkg::DIV_MAG_W'(prod_r);
    div_req.divisor = intv_r;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    vel_nxt       = vel_r;
    penc_nxt      = penc_r;
    seen_nxt      = seen_r;
    prng_nxt      = prng_r;
    prng_ok_nxt   = prng_ok_r;
    slip_nxt      = slip_r;
    acc_nxt       = acc_r;
    mm_nxt        = mm_r;
    err_nxt       = err_r;
    gain_nxt      = gain_r;
    mul_a         = '0;
    mul_b         = '0;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          acc_nxt   = 1'b0;
          state_nxt = S_OUT;
          case (in_opcode)
            etpe_pkg::OP_UPDATE: begin
              acc_nxt   = in_range_flag && (in_range_mm >= min_rng_r);
              state_nxt = mode_r ? S_RNG : S_ENC;
            end
            etpe_pkg::OP_FORCE: begin
              pos_nxt  = in_forced_position;
              vel_nxt  = '0;
              slip_nxt = 1'b0;
            end
            etpe_pkg::OP_RESYNC: begin
              penc_nxt = in_encoder_count;
              seen_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      // Range-only: position from the reading, velocity from successive readings
      S_RNG: begin
        prng_ok_nxt = acc_r;
        slip_nxt    = 1'b0;
        vel_nxt     = '0;
        state_nxt   = S_OUT;
        if (acc_r) begin
          pos_nxt  = $signed({8'd0, rng_r, 8'd0});
          prng_nxt = rng_r;
          if (prng_ok_r && !intv_zero) begin
            mm_nxt    = etpe_pkg::MUL_A_W'($signed({rdiff, 8'd0}));
            state_nxt = S_VMUL;
          end
        end
      end
      // Fusion: scale the wrapped encoder delta
      S_ENC: begin
        mul_a       = etpe_pkg::MUL_A_W'($signed(delta));
        mul_b       = mpc_r;
        penc_nxt    = enc_r;
        seen_nxt    = 1'b1;
        prng_ok_nxt = acc_r;
        slip_nxt    = 1'b0;
        state_nxt   = S_POS;
      end
      // Integrate the rounded delta, clamp it for the velocity
      S_POS: begin
        pos_nxt = sat32(SUM_W'(pos_r) + SUM_W'(dmm));
        vel_nxt = '0;
        if (dmm > MM_LIM) begin
          mm_nxt = etpe_pkg::MUL_A_W'(MM_LIM);
        end else if (dmm < -MM_LIM) begin
          mm_nxt = etpe_pkg::MUL_A_W'(-MM_LIM);
        end else begin
          mm_nxt = dmm[etpe_pkg::MUL_A_W-1:0];
        end
        if (!intv_zero) begin
          state_nxt = S_VMUL;
        end else begin
          state_nxt = acc_r ? S_ERR : S_OUT;
        end
      end
      S_VMUL: begin
        mul_a     = mm_r;
        mul_b     = VEL_SCALE;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        state_nxt = S_DIVW;
      end
      // Wait for the quotient
      S_DIVW: begin
        if (div_rsp.done) begin
          vel_nxt   = div_rsp.quot;
          state_nxt = (!mode_r && acc_r) ? S_ERR : S_OUT;
        end
      end
      // Range error, slip decision and gain choice
      S_ERR: begin
        prng_nxt  = rng_r;
        slip_nxt  = slip_now;
        err_nxt   = err;
        gain_nxt  = gain_sel;
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        mul_a     = etpe_pkg::MUL_A_W'(err_r);
        mul_b     = etpe_pkg::MUL_B_W'($signed({1'b0, gain_r}));
        state_nxt = S_CPOS;
      end
      // Apply the rounded correction
      S_CPOS: begin
        pos_nxt   = sat32(SUM_W'(pos_r) + SUM_W'(corr));
        state_nxt = S_OUT;
      end
      // Hand the item to the output register
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and estimator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      vel_r       <= '0;
      penc_r      <= '0;
      seen_r      <= 1'b0;
      prng_r      <= '0;
      prng_ok_r   <= 1'b0;
      slip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      vel_r       <= vel_nxt;
      penc_r      <= penc_nxt;
      seen_r      <= seen_nxt;
      prng_r      <= prng_nxt;
      prng_ok_r   <= prng_ok_nxt;
      slip_r      <= slip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      enc_r  <= in_encoder_count;
      rng_r  <= in_range_mm;
      intv_r <= in_interval_us;
    end
    acc_r  <= acc_nxt;
    mm_r   <= mm_nxt;
    err_r  <= err_nxt;
    gain_r <= gain_nxt;
    prod_r <= prod_nxt;
    if (out_load) begin
      out_pos_r  <= pos_r;
      out_vel_r  <= vel_r;
      out_rng_r  <= prng_r;
      out_acc_r  <= acc_r;
      out_slip_r <= slip_r;
    end
  end

  assign out_position        = out_pos_r;
  assign out_velocity        = out_vel_r;
  assign out_latest_range_mm = out_rng_r;
  assign out_range_accepted  = out_acc_r;
  assign out_slip_flag       = out_slip_r;

endmodule
